// ===== design/pulse_duration_to_symbol_packer_core_assert.svh =====
// assertion macros for the pulse duration to symbol packer
`ifndef PULSE_DURATION_TO_SYMBOL_PACKER_CORE_ASSERT_SVH
`define PULSE_DURATION_TO_SYMBOL_PACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PDSP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pdsp invariant violated");
`define PDSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdsp sequence violated");
`else
`define PDSP_ASSERT_ALWAYS(lbl, expr)
`define PDSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/pdsp_pkg.sv =====
// shared types and constants for the pulse duration to symbol packer
`timescale 1ns / 1ps
package pdsp_pkg;

  localparam int DurBits   = 16;
  localparam int SlotBits  = 15;
  localparam int LenBits   = 15;
  localparam int CalcBits  = DurBits + 3;
  localparam int FifoDepth = 4;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int CntBits   = $clog2(FifoDepth + 1);

  localparam logic [CalcBits-1:0] SlotMax  = CalcBits'((64'd1 << SlotBits) - 64'd1);
  localparam logic [CalcBits-1:0] SatLimit = CalcBits'(3 * ((64'd1 << SlotBits) - 64'd1));

  typedef struct packed {
    logic               level;
    logic [LenBits-1:0] len;
  } half_t;

  typedef struct packed {
    logic  final_word;
    half_t second;
    half_t first;
  } word_t;

  typedef struct packed {
    logic  valid;
    half_t half;
  } held_t;

  typedef struct packed {
    logic [1:0] count;
    word_t      word_a;
    word_t      word_b;
    held_t      held;
    logic       next_level;
  } build_t;

endpackage

// ===== design/pdsp_word_build.sv =====
// splits one duration into chunks and pairs half-slots into symbol words
`timescale 1ns / 1ps
module pdsp_word_build
  import pdsp_pkg::*;
(
  input  logic [DurBits-1:0] duration,
  input  logic               burst_end,
  input  held_t              held,
  input  logic               next_level,
  output build_t             result
);

  logic [CalcBits-1:0] dur;
  logic [CalcBits-1:0] c1;
  logic [CalcBits-1:0] rem1;
  logic [CalcBits-1:0] c2;
  logic [CalcBits-1:0] c3;
  logic [2:0]          chunks;
  logic [2:0]          total;
  half_t               h0, h1, h2, h3;
  half_t               ch1, ch2, ch3;
  half_t               zero_half;

  always_comb begin
    zero_half = '0;
    dur = (duration == '0) ? CalcBits'(1) : CalcBits'(duration);
    if (dur > SatLimit) begin
      dur = SatLimit;
    end
    c1   = (dur > SlotMax) ? SlotMax : dur;
    rem1 = dur - c1;
    c2   = (rem1 > SlotMax) ? SlotMax : rem1;
    c3   = rem1 - c2;
    chunks = 3'd1 + ((rem1 != '0) ? 3'd1 : 3'd0) + ((c3 != '0) ? 3'd1 : 3'd0);
    total  = chunks + (held.valid ? 3'd1 : 3'd0);

    ch1 = '{level: next_level, len: c1[LenBits-1:0]};
    ch2 = '{level: next_level, len: c2[LenBits-1:0]};
    ch3 = '{level: next_level, len: c3[LenBits-1:0]};

    if (held.valid) begin
      h0 = held.half;
      h1 = ch1;
      h2 = ch2;
      h3 = ch3;
    end else begin
      h0 = ch1;
      h1 = ch2;
      h2 = ch3;
      h3 = zero_half;
    end

    // words go out as halves pair up; an odd tail waits or closes the burst
    result.word_a.first  = h0;
    result.word_a.second = (total >= 3'd2) ? h1 : zero_half;
    result.word_b.first  = h2;
    result.word_b.second = (total == 3'd4) ? h3 : zero_half;

    if (total >= 3'd2) begin
      result.count = ((total == 3'd4) || (total == 3'd3 && burst_end)) ? 2'd2 : 2'd1;
    end else begin
      result.count = burst_end ? 2'd1 : 2'd0;
    end
    result.word_a.final_word = burst_end && (result.count == 2'd1);
    result.word_b.final_word = burst_end;

    if (total[0] && !burst_end) begin
      result.held.valid = 1'b1;
      result.held.half  = (total == 3'd1) ? h0 : h2;
    end else begin
      result.held = '0;
    end
    result.next_level = burst_end ? 1'b1 : ~next_level;
  end

endmodule

// ===== design/pulse_duration_to_symbol_packer_core.sv =====
// top level of the pulse duration to symbol packer
//
//   port group  dir  contents
//   s_*         in   duration request, tlast = end of burst
//   m_*         out  symbol word, tlast = last word of burst
//
// a request is registered, then split and paired combinationally into 0 to 2 words
// that enter a 4-entry output queue; with m_tready high it drains a word per cycle
// and the core sustains one request per cycle for 0 or 1 words, not for 2 words
// a registered request is processed only when the queue has room for two words
// rst is synchronous and clears the request register, queue and pending half
`timescale 1ns / 1ps
module pulse_duration_to_symbol_packer_core
  import pdsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] duration
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [0] first_level, [15:1] first_length,
                                // [16] second_level, [31:17] second_length
  output logic        m_tlast
);

`include "pulse_duration_to_symbol_packer_core_assert.svh"

  logic               in_valid;
  logic [DurBits-1:0] in_duration;
  logic               in_last;
  held_t              held;
  logic               next_level;
  build_t             build;
  logic               proc;
  logic               pop;

  word_t              fifo [FifoDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;
  logic [CntBits-1:0] count_next;
  word_t              head;

  pdsp_word_build u_build (
    .duration   (in_duration),
    .burst_end  (in_last),
    .held       (held),
    .next_level (next_level),
    .result     (build)
  );

  assign proc     = in_valid && (count <= CntBits'(FifoDepth - 2));
  assign s_tready = !in_valid || proc;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = fifo[rd_ptr];
  assign m_tdata  = {head.second.len, head.second.level, head.first.len, head.first.level};
  assign m_tlast  = head.final_word;

  always_comb begin
    count_next = count;
    if (proc) begin
      count_next = count_next + CntBits'(build.count);
    end
    if (pop) begin
      count_next = count_next - CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      held       <= '0;
      next_level <= 1'b1;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (proc) begin
        held       <= build.held;
        next_level <= build.next_level;
        wr_ptr     <= wr_ptr + PtrBits'(build.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_duration <= s_tdata[DurBits-1:0];
      in_last     <= s_tlast;
    end
    if (proc && build.count != 2'd0) begin
      fifo[wr_ptr] <= build.word_a;
    end
    if (proc && build.count == 2'd2) begin
      fifo[wr_ptr + PtrBits'(1)] <= build.word_b;
    end
  end

  `PDSP_ASSERT_ALWAYS(a_count_in_range, count <= CntBits'(FifoDepth))
  `PDSP_ASSERT_NEXT(a_burst_end_clears_held, proc && in_last, !held.valid && next_level)
  `PDSP_ASSERT_NEXT(a_pending_half_holds, !proc, $stable(held) && $stable(next_level))

endmodule
